### sv/leg_inverse_kinematics_assert.svh
// ----------------------------------------------------------------------------
// leg inverse kinematics assertion macros
// Shared property forms for the port-level checker, clocked on clk and
// disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef LEG_INVERSE_KINEMATICS_ASSERT_SVH
`define LEG_INVERSE_KINEMATICS_ASSERT_SVH

// same-cycle implication
`define LIK_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LIK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/lik_pkg.sv
// ----------------------------------------------------------------------------
// lik_pkg
// Widths, register codes and arctangent constants for the leg inverse
// kinematics block.
// ----------------------------------------------------------------------------
package lik_pkg;

  localparam int PosW     = 20;  // Q3.16 positions
  localparam int LenW     = 19;  // Q3.16 link lengths
  localparam int AngW     = 16;  // binary angle, 65536 per turn
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 20;

  localparam int AtanInW    = 53;  // widest vector component fed to atan2
  localparam int PreW       = 30;  // magnitude bound before rotation
  localparam int CordicW    = 33;
  localparam int AtanTabLen = 24;

  localparam logic [AngW-1:0] HalfTurn = 16'h8000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HIP_POS_X  = 3'd0,
    REG_HIP_POS_Y  = 3'd1,
    REG_HIP_POS_Z  = 3'd2,
    REG_UPPER_LEN  = 3'd3,
    REG_LOWER_LEN  = 3'd4,
    REG_WAIST_ZERO = 3'd5,
    REG_HIP_ZERO   = 3'd6,
    REG_KNEE_ZERO  = 3'd7
  } cfg_reg_t;

  localparam logic signed [PosW-1:0] HipPosYReset  = 20'sd13107;
  localparam logic [LenW-1:0]        UpperLenReset = 19'd18350;
  localparam logic [LenW-1:0]        LowerLenReset = 19'd24576;

  // atan(2^-i) with 2^32 units per turn
  localparam logic [31:0] AtanTab [AtanTabLen] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

endpackage

### sv/lik_atan2.sv
// ----------------------------------------------------------------------------
// lik_atan2
// Pipelined vectoring CORDIC: binary angle of (x, y), one rotation per
// stage, one vector per cycle while en is high.
// ----------------------------------------------------------------------------
module lik_atan2 #(
  parameter int STEPS = 16
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [lik_pkg::AtanInW-1:0]  y,
  input  logic signed [lik_pkg::AtanInW-1:0]  x,
  output logic        [lik_pkg::AngW-1:0]     angle
);
  import lik_pkg::*;

  localparam int ShW = $clog2(AtanInW);

  typedef struct packed {
    logic xn;
    logic yn;
    logic zero;
  } quad_t;

  // magnitudes and quadrant
  logic [AtanInW-1:0] ax1, ay1, ax2, ay2;
  quad_t              q1, q2;
  logic [ShW-1:0]     kc, k2;
  logic [AtanInW-1:0] mag_or, axs, ays;

  logic signed [CordicW-1:0] cx [STEPS+1];
  logic signed [CordicW-1:0] cy [STEPS+1];
  logic signed [CordicW-1:0] cz [STEPS+1];
  quad_t                     fl [STEPS+1];

  logic [CordicW-1:0] zr;
  logic [AngW-1:0]    a0, a1, a2;

  always_ff @(posedge clk) begin
    if (en) begin
      ax1     <= x[AtanInW-1] ? $unsigned(-x) : $unsigned(x);
      ay1     <= y[AtanInW-1] ? $unsigned(-y) : $unsigned(y);
      q1.xn   <= x[AtanInW-1];
      q1.yn   <= y[AtanInW-1];
      q1.zero <= (x == '0) && (y == '0);
    end
  end

  // shift that brings both magnitudes below 2^30
  assign mag_or = ax1 | ay1;
  always_comb begin
    kc = '0;
    for (int i = PreW; i < AtanInW; i++) begin
      if (mag_or[i]) kc = ShW'(i - PreW + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax2 <= ax1;
      ay2 <= ay1;
      q2  <= q1;
      k2  <= kc;
    end
  end

  assign axs = ax2 >> k2;
  assign ays = ay2 >> k2;

  always_ff @(posedge clk) begin
    if (en) begin
      cx[0] <= $signed(CordicW'(axs[PreW-1:0]));
      cy[0] <= $signed(CordicW'(ays[PreW-1:0]));
      cz[0] <= '0;
      fl[0] <= q2;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (cy[i] > 0) begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + $signed(CordicW'(AtanTab[i]));
        end else begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - $signed(CordicW'(AtanTab[i]));
        end
        fl[i+1] <= fl[i];
      end
    end
  end

  // round to 1/65536 turn, ties up, then unfold the quadrant
  assign zr = cz[STEPS] + CordicW'(32768);
  assign a0 = zr[2*AngW-1:AngW];
  assign a1 = fl[STEPS].xn ? HalfTurn - a0 : a0;
  assign a2 = fl[STEPS].yn ? AngW'(0) - a1 : a1;

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= fl[STEPS].zero ? '0 : a2;
    end
  end

endmodule

### sv/leg_inverse_kinematics.sv
// ----------------------------------------------------------------------------
// leg_inverse_kinematics
// Foot target to waist, hip and knee angles for a roll waist plus a
// two-link planar leg, elbow-down knee.
//
// Target channel: target_valid / target_stall with target_x/y/z; a word is
// taken at an edge where valid is high and stall is low. Result channel:
// result_valid / result_stall with the three angles and out_of_reach.
// Configuration: cfg_valid / cfg_ready with cfg_index / cfg_data; cfg_ready
// is always high. Write registers only while no target is in flight.
// Throughput is one target per cycle while target_stall is low. From
// acceptance to result_valid a target passes through squares and
// law-of-cosines setup, two one-bit-per-stage square roots, products,
// four parallel CORDIC pipelines and the final and output registers.
// Unreachable targets return out_of_reach with zero angles. A stalled
// result waits in the output register while one more word lands in a
// skid register; only then is target_stall raised, and the whole
// pipeline holds until the receiver drains the skid.
// Reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module leg_inverse_kinematics #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 target_valid,
  output logic                                 target_stall,
  input  logic signed [lik_pkg::PosW-1:0]     target_x,
  input  logic signed [lik_pkg::PosW-1:0]     target_y,
  input  logic signed [lik_pkg::PosW-1:0]     target_z,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic signed [lik_pkg::AngW-1:0]     waist_angle,
  output logic signed [lik_pkg::AngW-1:0]     hip_angle,
  output logic signed [lik_pkg::AngW-1:0]     knee_angle,
  output logic                                 out_of_reach,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lik_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [lik_pkg::CfgDataW-1:0]        cfg_data
);
  import lik_pkg::*;

  localparam int DiffW     = PosW + 1;
  localparam int SqW       = 2 * DiffW - 1;
  localparam int D2W       = SqW + 1;
  localparam int NW        = D2W + 2;
  localparam int DW        = 2 * LenW + 1;
  localparam int SqrtW     = 62;
  localparam int SqrtSteps = SqrtW / 2;
  localparam int RootW     = SqrtSteps;
  localparam int NcW       = RootW + 1;
  localparam int KW        = 4;
  localparam int ProdW     = LenW + RootW + 1;
  localparam int AtanLat   = CORDIC_STEPS + 4;

  typedef struct packed {
    logic signed [DiffW-1:0] s;
    logic signed [DiffW-1:0] t;
    logic signed [DiffW-1:0] dx;
  } geo_t;

  typedef struct packed {
    geo_t                  g;
    logic signed [NcW-1:0] nc;
    logic [RootW-1:0]      dn;
    logic                  oor;
  } back_t;

  typedef struct packed {
    logic [AngW-1:0] waist;
    logic [AngW-1:0] hip;
    logic [AngW-1:0] knee;
    logic            oor;
  } res_t;

  // configuration registers
  logic signed [PosW-1:0] hip_pos_x, hip_pos_y, hip_pos_z;
  logic [LenW-1:0]        upper_link_len, lower_link_len;
  logic [AngW-1:0]        waist_zero, hip_zero, knee_zero;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hip_pos_x      <= '0;
      hip_pos_y      <= HipPosYReset;
      hip_pos_z      <= '0;
      upper_link_len <= UpperLenReset;
      lower_link_len <= LowerLenReset;
      waist_zero     <= '0;
      hip_zero       <= '0;
      knee_zero      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_HIP_POS_X:  hip_pos_x      <= $signed(cfg_data[PosW-1:0]);
        REG_HIP_POS_Y:  hip_pos_y      <= $signed(cfg_data[PosW-1:0]);
        REG_HIP_POS_Z:  hip_pos_z      <= $signed(cfg_data[PosW-1:0]);
        REG_UPPER_LEN:  upper_link_len <= cfg_data[LenW-1:0];
        REG_LOWER_LEN:  lower_link_len <= cfg_data[LenW-1:0];
        REG_WAIST_ZERO: waist_zero     <= cfg_data[AngW-1:0];
        REG_HIP_ZERO:   hip_zero       <= cfg_data[AngW-1:0];
        REG_KNEE_ZERO:  knee_zero      <= cfg_data[AngW-1:0];
        default: ;
      endcase
    end
  end

  // link-length terms, registered from the link-length registers
  logic [LenW:0]     lsum;
  logic [LenW-1:0]   ldiff;
  logic [2*LenW-1:0] l1sq, l2sq, l1l2, diffsq;
  logic [2*LenW+1:0] sumsq;
  logic              lzero;

  always_ff @(posedge clk) begin
    lsum   <= (LenW+1)'(upper_link_len) + (LenW+1)'(lower_link_len);
    ldiff  <= (upper_link_len > lower_link_len) ? upper_link_len - lower_link_len
                                                : lower_link_len - upper_link_len;
    lzero  <= (upper_link_len == '0) || (lower_link_len == '0);
    l1sq   <= upper_link_len * upper_link_len;
    l2sq   <= lower_link_len * lower_link_len;
    l1l2   <= upper_link_len * lower_link_len;
    sumsq  <= lsum * lsum;
    diffsq <= ldiff * ldiff;
  end

  // handshake and pipeline enable
  logic skid_valid, pipe_en, acc;

  assign pipe_en      = !skid_valid;
  assign target_stall = skid_valid;
  assign acc          = target_valid && !target_stall;

  // front stages
  geo_t                     g1, g2, g3, g4, g5, g6, g7;
  logic [SqW-1:0]           ss2, tt2, xx2;
  logic signed [2*DiffW-1:0] ss_c, tt_c, xx_c;
  logic [D2W-1:0]           sq3, sq4, sq5, sq6, sq7, d23;
  logic                     oor4, oor5, oor6, oor7;
  logic signed [NW-1:0]     n4, n5, dpos, ncc, nabs;
  logic [DW-1:0]            d4;
  logic [KW-1:0]            kc;
  logic [RootW-1:0]         dn5, dn6, dn7, an6;
  logic signed [NcW-1:0]    nc6, nc7;
  logic [SqrtW-1:0]         dd7, aa7;
  logic                     v1, v2, v3, v4, v5, v6, v7;

  assign ss_c = g1.s * g1.s;
  assign tt_c = g1.t * g1.t;
  assign xx_c = g1.dx * g1.dx;

  // normalize the cosine denominator below 2^31
  always_comb begin
    kc = '0;
    for (int i = RootW; i < DW; i++) begin
      if (d4[i]) kc = KW'(i - RootW + 1);
    end
  end

  // clamp the cosine numerator to [-d, d]
  always_comb begin
    dpos = $signed(NW'(dn5));
    if (n5 > dpos) begin
      ncc = dpos;
    end else if (n5 < -dpos) begin
      ncc = -dpos;
    end else begin
      ncc = n5;
    end
    nabs = (ncc < 0) ? -ncc : ncc;
  end

  // square-root lanes: 0 is the knee sine, 1 is the planar reach
  logic [SqrtW-1:0] rem  [2][SqrtSteps+1];
  logic [SqrtW-1:0] root [2][SqrtSteps+1];
  back_t            cq   [SqrtSteps+1];
  logic             vq   [SqrtSteps+1];

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      g1.s  <= DiffW'(target_y) - DiffW'(hip_pos_y);
      g1.t  <= DiffW'(target_z) - DiffW'(hip_pos_z);
      g1.dx <= DiffW'(hip_pos_x) - DiffW'(target_x);

      g2  <= g1;
      ss2 <= ss_c[SqW-1:0];
      tt2 <= tt_c[SqW-1:0];
      xx2 <= xx_c[SqW-1:0];

      g3  <= g2;
      sq3 <= D2W'(ss2) + D2W'(tt2);
      d23 <= D2W'(ss2) + D2W'(tt2) + D2W'(xx2);

      g4   <= g3;
      sq4  <= sq3;
      oor4 <= lzero || (d23 > D2W'(sumsq)) || (d23 < D2W'(diffsq));
      n4   <= $signed(NW'(d23)) - $signed(NW'(l1sq)) - $signed(NW'(l2sq));
      d4   <= {l1l2, 1'b0};

      g5   <= g4;
      sq5  <= sq4;
      oor5 <= oor4;
      n5   <= n4 >>> kc;
      dn5  <= RootW'(d4 >> kc);

      g6   <= g5;
      sq6  <= sq5;
      oor6 <= oor5;
      nc6  <= ncc[NcW-1:0];
      an6  <= nabs[RootW-1:0];
      dn6  <= dn5;

      g7   <= g6;
      sq7  <= sq6;
      oor7 <= oor6;
      nc7  <= nc6;
      dn7  <= dn6;
      dd7  <= dn6 * dn6;
      aa7  <= an6 * an6;

      rem[0][0]  <= dd7 - aa7;
      rem[1][0]  <= SqrtW'({sq7, 16'h0000});
      root[0][0] <= '0;
      root[1][0] <= '0;
      cq[0]      <= '{g: g7, nc: nc7, dn: dn7, oor: oor7};
      for (int j = 0; j < SqrtSteps; j++) begin
        cq[j+1] <= cq[j];
      end
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    for (genvar j = 0; j < SqrtSteps; j++) begin : g_bit
      localparam logic [SqrtW-1:0] Bit = SqrtW'(1) << (SqrtW - 2 - 2 * j);
      logic [SqrtW-1:0] trial;
      assign trial = root[l][j] + Bit;
      always_ff @(posedge clk) begin
        if (pipe_en) begin
          if (rem[l][j] >= trial) begin
            rem[l][j+1]  <= rem[l][j] - trial;
            root[l][j+1] <= (root[l][j] >> 1) + Bit;
          end else begin
            rem[l][j+1]  <= rem[l][j];
            root[l][j+1] <= root[l][j] >> 1;
          end
        end
      end
    end
  end

  // products for the hip correction vector
  back_t                   cm1;
  logic [RootW-1:0]        w_m1, r8_m1;
  logic [ProdW-1:0]        l2w_m1, l1d_m1;
  logic signed [ProdW-1:0] l2n_m1, l2n_c;
  logic                    vm1;

  assign l2n_c = $signed({1'b0, lower_link_len}) * cq[SqrtSteps].nc;

  // atan2 operands
  logic signed [AtanInW-1:0] wy, wx, ky, kx, h1y, h1x, h2y, h2x;
  logic [AngW-1:0]           a_waist, a_knee, a_hip1, a_hip2;
  logic                      dl_v   [AtanLat+1];
  logic                      dl_oor [AtanLat+1];

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      cm1    <= cq[SqrtSteps];
      w_m1   <= root[0][SqrtSteps][RootW-1:0];
      r8_m1  <= root[1][SqrtSteps][RootW-1:0];
      l2w_m1 <= lower_link_len * root[0][SqrtSteps][RootW-1:0];
      l1d_m1 <= upper_link_len * cq[SqrtSteps].dn;
      l2n_m1 <= l2n_c;

      wy  <= AtanInW'(cm1.g.s);
      wx  <= -AtanInW'(cm1.g.t);
      ky  <= -$signed(AtanInW'(w_m1));
      kx  <= AtanInW'(cm1.nc);
      h1y <= AtanInW'(cm1.g.dx) <<< 8;
      h1x <= -$signed(AtanInW'(r8_m1));
      h2y <= -$signed(AtanInW'(l2w_m1));
      h2x <= $signed(AtanInW'(l1d_m1)) + AtanInW'(l2n_m1);

      dl_oor[0] <= cm1.oor;
      for (int i = 0; i < AtanLat; i++) begin
        dl_oor[i+1] <= dl_oor[i];
      end
    end
  end

  lik_atan2 #(.STEPS(CORDIC_STEPS)) u_atan_waist (
    .clk(clk), .en(pipe_en), .y(wy), .x(wx), .angle(a_waist)
  );
  lik_atan2 #(.STEPS(CORDIC_STEPS)) u_atan_knee (
    .clk(clk), .en(pipe_en), .y(ky), .x(kx), .angle(a_knee)
  );
  lik_atan2 #(.STEPS(CORDIC_STEPS)) u_atan_hip1 (
    .clk(clk), .en(pipe_en), .y(h1y), .x(h1x), .angle(a_hip1)
  );
  lik_atan2 #(.STEPS(CORDIC_STEPS)) u_atan_hip2 (
    .clk(clk), .en(pipe_en), .y(h2y), .x(h2x), .angle(a_hip2)
  );

  // final angles with offsets, all zero when out of reach
  res_t fres, od, sd;
  logic fv;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      if (dl_oor[AtanLat]) begin
        fres <= '{waist: '0, hip: '0, knee: '0, oor: 1'b1};
      end else begin
        fres.waist <= a_waist + HalfTurn - waist_zero;
        fres.hip   <= a_hip1 - a_hip2 - hip_zero;
        fres.knee  <= a_knee - knee_zero;
        fres.oor   <= 1'b0;
      end
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      v4  <= 1'b0;
      v5  <= 1'b0;
      v6  <= 1'b0;
      v7  <= 1'b0;
      vm1 <= 1'b0;
      fv  <= 1'b0;
      for (int j = 0; j <= SqrtSteps; j++) vq[j] <= 1'b0;
      for (int i = 0; i <= AtanLat; i++) dl_v[i] <= 1'b0;
    end else if (pipe_en) begin
      v1    <= acc;
      v2    <= v1;
      v3    <= v2;
      v4    <= v3;
      v5    <= v4;
      v6    <= v5;
      v7    <= v6;
      vq[0] <= v7;
      for (int j = 0; j < SqrtSteps; j++) vq[j+1] <= vq[j];
      vm1       <= vq[SqrtSteps];
      dl_v[0]   <= vm1;
      for (int i = 0; i < AtanLat; i++) dl_v[i+1] <= dl_v[i];
      fv <= dl_v[AtanLat];
    end
  end

  // output register plus one skid word
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (!result_stall) skid_valid <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      result_valid <= fv;
    end else if (fv) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (!result_stall) od <= sd;
    end else if (!result_valid || !result_stall) begin
      if (fv) od <= fres;
    end else if (fv) begin
      sd <= fres;
    end
  end

  assign waist_angle  = $signed(od.waist);
  assign hip_angle    = $signed(od.hip);
  assign knee_angle   = $signed(od.knee);
  assign out_of_reach = od.oor;

endmodule

### sv/lik_checker.sv
// ----------------------------------------------------------------------------
// lik_checker
// Port-level checks on the result channel and the input back-pressure of
// the leg inverse kinematics block.
// ----------------------------------------------------------------------------
`include "leg_inverse_kinematics_assert.svh"

module lik_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 target_stall,
  input logic                                 result_valid,
  input logic                                 result_stall,
  input logic signed [lik_pkg::AngW-1:0]     waist_angle,
  input logic signed [lik_pkg::AngW-1:0]     hip_angle,
  input logic signed [lik_pkg::AngW-1:0]     knee_angle,
  input logic                                 out_of_reach
);

  `LIK_ASSERT_NEXT(a_hold_valid, result_valid && result_stall, result_valid, "stalled result word dropped")
  `LIK_ASSERT_NEXT(a_hold_word, result_valid && result_stall, $stable(waist_angle) && $stable(hip_angle) && $stable(knee_angle) && $stable(out_of_reach), "stalled result word changed")
  `LIK_ASSERT_NOW(a_reach_zero, result_valid && out_of_reach, waist_angle == '0 && hip_angle == '0 && knee_angle == '0, "unreachable target with nonzero angle")
  `LIK_ASSERT_NOW(a_stall_cause, target_stall, $past(result_valid && result_stall), "input stalled without output back-pressure")
  `LIK_ASSERT_NOW(a_stall_word, target_stall, result_valid, "input stalled while output register empty")

endmodule

bind leg_inverse_kinematics lik_checker u_lik_checker (.*);

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Leg inverse kinematics testbench. Directed targets at the edges of reach,
// then register sweeps and random targets about the hip. Every result word
// is checked against an in-bench prediction of the three joint angles and out_of_reach.
// ----------------------------------------------------------------------------
module tb;
  import lik_pkg::*;

  localparam int CordicSteps = 16;
  localparam int Latency     = CordicSteps + 47;
  localparam int CycleLimit  = 600000;

  typedef struct packed {
    logic [AngW-1:0] waist;
    logic [AngW-1:0] hip;
    logic [AngW-1:0] knee;
    logic            oor;
  } joint_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic target_valid = 1'b0;
  logic target_stall;
  logic signed [PosW-1:0] target_x = '0, target_y = '0, target_z = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [AngW-1:0] waist_angle, hip_angle, knee_angle;
  logic out_of_reach;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  leg_inverse_kinematics #(.CORDIC_STEPS(CordicSteps)) dut (.*);

  logic [CfgDataW-1:0] leg_regs [8];
  joint_cmd_t pending_cmds[$];
  int fails = 0;
  int cycles = 0;
  bit quiet = 0;

  initial forever #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("leg_inverse_kinematics verification failed");
      $finish;
    end
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // vectoring cordic, 2^32 units per turn rounded to 1/65536 turn
  function automatic logic [AngW-1:0] bin_atan2(longint y, longint x);
    longint ax, ay, cx, cy, z, nx;
    logic [AngW-1:0] a;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    z = 0;
    if (ax == 0 && ay == 0) return '0;
    while (ax >= (64'sd1 << 30) || ay >= (64'sd1 << 30)) begin
      ax >>= 1;
      ay >>= 1;
    end
    cx = ax;
    cy = ay;
    for (int i = 0; i < CordicSteps && i < AtanTabLen; i++) begin
      if (cy > 0) begin
        nx = cx + (cy >>> i);
        cy = cy - (cx >>> i);
        z += longint'(AtanTab[i]);
      end else begin
        nx = cx - (cy >>> i);
        cy = cy + (cx >>> i);
        z -= longint'(AtanTab[i]);
      end
      cx = nx;
    end
    a = AngW'((z + 32768) >>> 16);
    if (x < 0) a = HalfTurn - a;
    if (y < 0) a = -a;
    return a;
  endfunction

  function automatic longint pos_reg(cfg_reg_t r);
    return longint'(signed'(leg_regs[r][PosW-1:0]));
  endfunction

  function automatic joint_cmd_t solve_leg(longint xd, longint yd, longint zd);
    joint_cmd_t c;
    longint s, t, dx, l1, l2, sq, d2, diff, n, d, an, w, r8;
    c = '0;
    s = yd - pos_reg(REG_HIP_POS_Y);
    t = zd - pos_reg(REG_HIP_POS_Z);
    dx = pos_reg(REG_HIP_POS_X) - xd;
    l1 = leg_regs[REG_UPPER_LEN][LenW-1:0];
    l2 = leg_regs[REG_LOWER_LEN][LenW-1:0];
    sq = s * s + t * t;
    d2 = sq + dx * dx;
    diff = (l1 > l2) ? l1 - l2 : l2 - l1;
    if (l1 == 0 || l2 == 0 || d2 > (l1 + l2) * (l1 + l2) || d2 < diff * diff) begin
      c.oor = 1'b1;
      return c;
    end
    c.waist = bin_atan2(s, -t) + HalfTurn - leg_regs[REG_WAIST_ZERO][AngW-1:0];
    n = d2 - l1 * l1 - l2 * l2;
    d = 2 * l1 * l2;
    while (d >= (64'sd1 << 31)) begin
      d >>= 1;
      n = n >>> 1;
    end
    if (n > d) n = d;
    if (n < -d) n = -d;
    an = (n < 0) ? -n : n;
    w = longint'(int_sqrt(d * d - an * an));
    c.knee = bin_atan2(-w, n) - leg_regs[REG_KNEE_ZERO][AngW-1:0];
    r8 = longint'(int_sqrt(sq << 16));
    c.hip = bin_atan2(dx * 256, -r8) - bin_atan2(-l2 * w, l1 * d + l2 * n)
            - leg_regs[REG_HIP_ZERO][AngW-1:0];
    return c;
  endfunction

  // result side: random stall bursts
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    joint_cmd_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_cmds.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result word");
      end else begin
        want = pending_cmds.pop_front();
        if (want.waist !== waist_angle || want.hip !== hip_angle ||
            want.knee !== knee_angle || want.oor !== out_of_reach) begin
          fails++;
          if (fails <= 10)
            $display("mismatch exp w=%0d h=%0d k=%0d o=%0b got w=%0d h=%0d k=%0d o=%0b",
                     $signed(want.waist), $signed(want.hip), $signed(want.knee), want.oor,
                     waist_angle, hip_angle, knee_angle, out_of_reach);
        end
      end
    end
  end

  task automatic send_target(longint x, longint y, longint z);
    joint_cmd_t c;
    c = solve_leg(x, y, z);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      target_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    target_valid <= 1'b1;
    target_x <= PosW'(x);
    target_y <= PosW'(y);
    target_z <= PosW'(z);
    do @(posedge clk); while (target_stall);
    pending_cmds.push_back(c);
  endtask

  task automatic drain;
    target_valid <= 1'b0;
    wait (pending_cmds.size() == 0);
    repeat (Latency + 8) @(posedge clk);
  endtask

  // idling after each write keeps valid low between writes
  task automatic write_reg(cfg_reg_t r, longint v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= CfgDataW'(v);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    leg_regs[r] = CfgDataW'(v) & ((r == REG_UPPER_LEN || r == REG_LOWER_LEN) ? 20'h7FFFF :
                  (r >= REG_WAIST_ZERO) ? 20'h0FFFF : 20'hFFFFF);
    @(posedge clk);
  endtask

  task automatic load_setup(longint hx, longint hy, longint hz, longint l1, longint l2,
                            longint wz, longint hz0, longint kz);
    write_reg(REG_HIP_POS_X, hx);
    write_reg(REG_HIP_POS_Y, hy);
    write_reg(REG_HIP_POS_Z, hz);
    write_reg(REG_UPPER_LEN, l1);
    write_reg(REG_LOWER_LEN, l2);
    write_reg(REG_WAIST_ZERO, wz);
    write_reg(REG_HIP_ZERO, hz0);
    write_reg(REG_KNEE_ZERO, kz);
  endtask

  function automatic longint clamp_pos(longint v);
    if (v > 524287) return 524287;
    if (v < -524288) return -524288;
    return v;
  endfunction

  // mostly targets in a box of the leg's reach about the hip, some full-range noise
  task automatic random_targets(int count);
    longint reach, hx, hy, hz;
    for (int i = 0; i < count; i++) begin
      hx = pos_reg(REG_HIP_POS_X);
      hy = pos_reg(REG_HIP_POS_Y);
      hz = pos_reg(REG_HIP_POS_Z);
      reach = leg_regs[REG_UPPER_LEN] + leg_regs[REG_LOWER_LEN] + 1;
      if ($urandom_range(0, 4) == 0)
        send_target(signed'(PosW'($urandom)), signed'(PosW'($urandom)),
                    signed'(PosW'($urandom)));
      else
        send_target(clamp_pos(hx + $urandom_range(0, 2 * reach) - reach),
                    clamp_pos(hy + $urandom_range(0, 2 * reach) - reach),
                    clamp_pos(hz + $urandom_range(0, 2 * reach) - reach));
    end
  endtask

  task automatic test_reset_defaults;
    // reach boundaries along x with the default hip and links
    send_target(-42926, 13107, 0);
    send_target(-42927, 13107, 0);
    send_target(-6226, 13107, 0);
    send_target(-6225, 13107, 0);
    send_target(6226, 13107, 0);
    send_target(-30000, 13107, 0);
    send_target(0, 13107 + 30000, 0);
    send_target(0, 13107, -30000);
    send_target(0, 13107, 30000);
    send_target(20000, 13107 - 20000, 10000);
    send_target(524287, 524287, 524287);
    send_target(-524288, -524288, -524288);
    send_target(0, 0, 0);
    drain();
  endtask

  task automatic test_extreme_setups;
    load_setup(524287, -524288, 524287, 524287, 524287, -32768, 32767, -32768);
    send_target(-524288, -524288, 524287);
    send_target(524287, 524287, -524288);
    send_target(0, 0, 0);
    random_targets(100);
    drain();
    load_setup(-524288, 524287, -524288, 1, 1, 32767, -32768, 32767);
    send_target(-524288, 524287, -524288);
    send_target(-524287, 524287, -524288);
    send_target(-524286, 524287, -524288);
    random_targets(60);
    drain();
  endtask

  task automatic test_zero_links;
    load_setup(0, 0, 0, 0, 24576, 0, 0, 0);
    random_targets(15);
    drain();
    write_reg(REG_UPPER_LEN, 18350);
    write_reg(REG_LOWER_LEN, 0);
    random_targets(15);
    drain();
  endtask

  task automatic test_random_setups;
    for (int p = 0; p < 4; p++) begin
      load_setup(signed'(PosW'($urandom)), signed'(PosW'($urandom)),
                 signed'(PosW'($urandom)), $urandom_range(1, 60000),
                 $urandom_range(1, (p == 2) ? 524287 : 60000), $urandom, $urandom, $urandom);
      if (p == 3) quiet = 1;
      random_targets(110);
      drain();
    end
  endtask

  initial begin
    for (int r = 0; r < 8; r++) leg_regs[r] = '0;
    leg_regs[REG_HIP_POS_Y] = CfgDataW'(HipPosYReset);
    leg_regs[REG_UPPER_LEN] = CfgDataW'(UpperLenReset);
    leg_regs[REG_LOWER_LEN] = CfgDataW'(LowerLenReset);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_extreme_setups();
    test_zero_links();
    test_random_setups();
    fails += pending_cmds.size();
    if (fails == 0) begin
      $display("leg_inverse_kinematics verification clean");
    end else begin
      $display("leg_inverse_kinematics verification failed");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+sv
sv/lik_pkg.sv
sv/lik_atan2.sv
sv/leg_inverse_kinematics.sv
sv/lik_checker.sv
tb/sv/tb.sv
